>>> design/rbsi_pkg.sv
package rbsi_pkg;

	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int THR_W   = 16;
	localparam int DIV_LAT = COORD_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0]        umag_t;

	localparam coord_t TMAX_C = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
	localparam coord_t CMIN_C = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

	typedef enum logic [0:0] {
		REG_ENTRY_MODE = 1'b0,
		REG_PAR_THRESH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
	} ray_t;

	typedef struct packed {
		logic   hit;
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} res_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] o;
		logic [2:0][COORD_W-1:0] dmag;
		logic [2:0]              dneg;
		logic [2:0]              par;
		logic [2:0]              in_slab;
	} side_t;

endpackage

>>> design/ray_box_slab_intersect_unit.sv
// Throughput: one ray per cycle; a stalled result stalls the whole pipeline.
// The crossing-time dividers set the depth: one quotient bit per stage.
// Reset: valid bits clear, entry_mode resets to 0, the threshold resets to 1.
module ray_box_slab_intersect_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_idx,
	input  logic [15:0]   cfg_wdata,
	input  logic          ray_valid,
	output logic          ray_ready,
	input  rbsi_pkg::ray_t ray,
	output logic          res_valid,
	input  logic          res_ready,
	output rbsi_pkg::res_t res
);
	import rbsi_pkg::*;

	logic             entry_mode_q;
	logic [THR_W-1:0] par_thr_q;
	logic             adv;

	coord_t o [3];
	coord_t d [3];
	coord_t lo [3];
	coord_t hi [3];

	logic                          v_s1;
	side_t                         side_s1;
	logic signed [COORD_W:0]       dlo_s1 [3];
	logic signed [COORD_W:0]       dhi_s1 [3];

	logic                          v_s2;
	side_t                         side_s2;
	umag_t                         nlo_s2 [3];
	umag_t                         nhi_s2 [3];
	logic                          neglo_s2 [3];
	logic                          neghi_s2 [3];

	logic [DIV_LAT-1:0]            vd_q;
	side_t                         sd_q [0:DIV_LAT-1];
	coord_t                        tlo [3];
	coord_t                        thi [3];

	logic                          v_s3;
	side_t                         side_s3;
	coord_t                        t1_s3 [3];
	coord_t                        t2_s3 [3];

	logic                          v_s4;
	side_t                         side_s4;
	logic                          hit_s4;
	umag_t                         tm_s4;
	logic                          tneg_s4;

	logic                          v_s5;
	side_t                         side_s5;
	logic                          hit_s5;
	logic [2*COORD_W-1:0]          prod_s5 [3];
	logic                          pneg_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_mode_q <= 1'b0;
			par_thr_q    <= THR_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ENTRY_MODE: entry_mode_q <= cfg_wdata[0];
				REG_PAR_THRESH: par_thr_q    <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = !res_valid || res_ready;
	assign ray_ready = adv;

	always_comb begin
		o[0]  = ray.origin_x;  o[1]  = ray.origin_y;  o[2]  = ray.origin_z;
		d[0]  = ray.dir_x;     d[1]  = ray.dir_y;     d[2]  = ray.dir_z;
		lo[0] = ray.box_min_x; lo[1] = ray.box_min_y; lo[2] = ray.box_min_z;
		hi[0] = ray.box_max_x; hi[1] = ray.box_max_y; hi[2] = ray.box_max_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vd_q <= '0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= ray_valid;
			v_s2 <= v_s1;
			vd_q <= {vd_q[DIV_LAT-2:0], v_s2};
			v_s3 <= vd_q[DIV_LAT-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			res_valid <= v_s5;
		end
	end

	// stage 1: slab offsets, direction magnitude, parallel test
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				side_s1.o[i]      <= o[i];
				side_s1.dmag[i]   <= d[i][COORD_W-1] ? umag_t'(-d[i]) : umag_t'(d[i]);
				side_s1.dneg[i]   <= d[i][COORD_W-1];
				side_s1.par[i]    <= (d[i] == '0) ||
					((d[i][COORD_W-1] ? umag_t'(-d[i]) : umag_t'(d[i])) <
					 COORD_W'(par_thr_q));
				side_s1.in_slab[i] <= (o[i] >= lo[i]) && (o[i] <= hi[i]);
				dlo_s1[i] <= (COORD_W+1)'(lo[i]) - (COORD_W+1)'(o[i]);
				dhi_s1[i] <= (COORD_W+1)'(hi[i]) - (COORD_W+1)'(o[i]);
			end
		end
	end

	// stage 2: numerator magnitudes and quotient signs
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) begin
				nlo_s2[i]   <= dlo_s1[i][COORD_W] ? COORD_W'(-dlo_s1[i]) : dlo_s1[i][COORD_W-1:0];
				nhi_s2[i]   <= dhi_s1[i][COORD_W] ? COORD_W'(-dhi_s1[i]) : dhi_s1[i][COORD_W-1:0];
				neglo_s2[i] <= dlo_s1[i][COORD_W] ^ side_s1.dneg[i];
				neghi_s2[i] <= dhi_s1[i][COORD_W] ^ side_s1.dneg[i];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		rbsi_divider #(.W(COORD_W), .F(FRAC_W)) u_div_lo (
			.clk (clk),
			.en  (adv),
			.n   (nlo_s2[i]),
			.d   (side_s2.dmag[i]),
			.neg (neglo_s2[i]),
			.t   (tlo[i])
		);
		rbsi_divider #(.W(COORD_W), .F(FRAC_W)) u_div_hi (
			.clk (clk),
			.en  (adv),
			.n   (nhi_s2[i]),
			.d   (side_s2.dmag[i]),
			.neg (neghi_s2[i]),
			.t   (thi[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[0] <= side_s2;
			for (int k = 1; k < DIV_LAT; k++) begin
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	// stage 3: sort crossing times
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= sd_q[DIV_LAT-1];
			for (int i = 0; i < 3; i++) begin
				t1_s3[i] <= (tlo[i] > thi[i]) ? thi[i] : tlo[i];
				t2_s3[i] <= (tlo[i] > thi[i]) ? tlo[i] : thi[i];
			end
		end
	end

	// stage 4: narrow the interval, pick the point parameter
	coord_t tmin;
	coord_t tmax;
	coord_t tsel;
	logic   par_ok;

	always_comb begin
		tmin   = '0;
		tmax   = TMAX_C;
		par_ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (side_s3.par[i]) begin
				par_ok = par_ok && side_s3.in_slab[i];
			end else begin
				if (t1_s3[i] > tmin) tmin = t1_s3[i];
				if (t2_s3[i] < tmax) tmax = t2_s3[i];
			end
		end
		tsel = entry_mode_q ? tmin : tmax;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			hit_s4  <= par_ok && (tmin <= tmax);
			tm_s4   <= tsel[COORD_W-1] ? umag_t'(-tsel) : umag_t'(tsel);
			tneg_s4 <= tsel[COORD_W-1];
		end
	end

	// stage 5: direction times parameter
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			hit_s5  <= hit_s4;
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= {{COORD_W{1'b0}}, side_s4.dmag[i]} *
					{{COORD_W{1'b0}}, tm_s4};
				pneg_s5[i] <= side_s4.dneg[i] ^ tneg_s4;
			end
		end
	end

	// stage 6: scale, offset from origin, saturate
	localparam logic [2*COORD_W-1:0] CAP = (2*COORD_W)'(1) << COORD_W;

	logic [2*COORD_W-1:0]    msh [3];
	logic [COORD_W:0]        mc  [3];
	logic signed [COORD_W+1:0] sum [3];
	coord_t                  pt  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msh[i] = prod_s5[i] >> FRAC_W;
			mc[i]  = (msh[i] > CAP) ? CAP[COORD_W:0] : msh[i][COORD_W:0];
			if (pneg_s5[i]) begin
				sum[i] = (COORD_W+2)'($signed(side_s5.o[i])) - $signed({1'b0, mc[i]});
			end else begin
				sum[i] = (COORD_W+2)'($signed(side_s5.o[i])) + $signed({1'b0, mc[i]});
			end
			if (sum[i] > (COORD_W+2)'(TMAX_C)) begin
				pt[i] = TMAX_C;
			end else if (sum[i] < (COORD_W+2)'(CMIN_C)) begin
				pt[i] = CMIN_C;
			end else begin
				pt[i] = sum[i][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.hit     <= hit_s5;
			res.point_x <= hit_s5 ? pt[0] : '0;
			res.point_y <= hit_s5 ? pt[1] : '0;
			res.point_z <= hit_s5 ? pt[2] : '0;
		end
	end

endmodule

>>> design/rbsi_divider.sv
module rbsi_divider #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [W-1:0]        n,
	input  logic [W-1:0]        d,
	input  logic                neg,
	output logic signed [W-1:0] t
);
	localparam int NW = W + F;
	localparam int CW = NW + W;
	localparam int SW = W - 1;
	localparam logic [W-1:0] TMAXV = {1'b0, {(W-1){1'b1}}};

	logic [NW-1:0] num;
	logic [NW-1:0] nsh;
	logic [CW-1:0] nx;
	logic [CW-1:0] dx;
	logic          ovf;

	logic [W-1:0]  rem_s  [0:SW];
	logic [SW-1:0] bits_s [0:SW];
	logic [SW-1:0] q_s    [0:SW];
	logic [W-1:0]  d_s    [0:SW];
	logic          ovf_s  [0:SW];
	logic          neg_s  [0:SW];

	logic [W-1:0]  val;

	always_comb begin
		num = {n, {F{1'b0}}};
		nsh = num >> (W - 1);
		nx  = CW'(num);
		dx  = CW'(d) << (W - 1);
		ovf = (nx >= dx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= nsh[W-1:0];
			bits_s[0] <= num[SW-1:0];
			q_s[0]    <= '0;
			d_s[0]    <= d;
			ovf_s[0]  <= ovf;
			neg_s[0]  <= neg;
		end
	end

	for (genvar j = 1; j <= SW; j++) begin : g_step
		logic [W:0] cand;
		logic       ge;
		always_comb begin
			cand = {rem_s[j-1], bits_s[j-1][SW-j]};
			ge   = (cand >= {1'b0, d_s[j-1]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? W'(cand - {1'b0, d_s[j-1]}) : cand[W-1:0];
				bits_s[j] <= bits_s[j-1];
				q_s[j]    <= {q_s[j-1][SW-2:0], ge};
				d_s[j]    <= d_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				neg_s[j]  <= neg_s[j-1];
			end
		end
	end

	always_comb begin
		val = ovf_s[SW] ? TMAXV : {1'b0, q_s[SW]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t <= neg_s[SW] ? $signed(W'(-val)) : $signed(val);
		end
	end

endmodule

>>> tb/ray_box_slab_intersect_unit_tb.sv
`timescale 1ns / 1ps
module ray_box_slab_intersect_unit_tb;
	import rbsi_pkg::*;

	localparam int LATENCY = COORD_W + 7;
	localparam longint TMAX_L = 64'sd2147483647;
	localparam longint CMIN_L = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = REG_ENTRY_MODE;
	logic [15:0] cfg_wdata = '0;
	logic ray_valid = 1'b0;
	logic ray_ready;
	ray_t ray = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	ray_box_slab_intersect_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .ray_valid(ray_valid), .ray_ready(ray_ready),
		.ray(ray), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ray_t pending_rays[$];
	res_t expected_hits[$];
	bit mode_entry = 1'b0;
	logic [15:0] par_thresh = 16'd1;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 1'b0;
	bit in_taken = 1'b0;
	int errors = 0;
	int rays_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int cycles = 0;

	function automatic longint umag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint slab_time(longint num, longint den);
		longint n, d, q, r, val;
		n = umag(num);
		d = umag(den);
		q = n / d;
		r = n % d;
		if (q > (TMAX_L >>> FRAC_W)) val = TMAX_L;
		else begin
			val = q;
			for (int i = 0; i < FRAC_W; i++) begin
				r = r <<< 1;
				val = val <<< 1;
				if (r >= d) begin
					r -= d;
					val |= 1;
				end
			end
		end
		return ((num < 0) != (den < 0)) ? -val : val;
	endfunction

	function automatic longint point_at(longint o, longint d, longint t);
		logic [127:0] prod;
		logic [127:0] sh;
		longint m, s;
		prod = 128'(umag(d)) * 128'(umag(t));
		sh = prod >> FRAC_W;
		if (sh > 128'(64'd1 << COORD_W)) m = 64'sd1 <<< COORD_W;
		else m = longint'(sh[63:0]);
		s = ((d < 0) != (t < 0)) ? o - m : o + m;
		if (s > TMAX_L) s = TMAX_L;
		if (s < CMIN_L) s = CMIN_L;
		return s;
	endfunction

	function automatic res_t slab_intersect(ray_t r);
		longint o[3], d[3], lo[3], hi[3], pt[3];
		longint tmin, tmax, t1, t2, x, t;
		bit hit;
		res_t e;
		o = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
		d = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
		lo = '{longint'(r.box_min_x), longint'(r.box_min_y), longint'(r.box_min_z)};
		hi = '{longint'(r.box_max_x), longint'(r.box_max_y), longint'(r.box_max_z)};
		tmin = 0;
		tmax = TMAX_L;
		hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (d[i] == 0 || umag(d[i]) < longint'(par_thresh)) begin
				if (o[i] < lo[i] || o[i] > hi[i]) hit = 1'b0;
			end else begin
				t1 = slab_time(lo[i] - o[i], d[i]);
				t2 = slab_time(hi[i] - o[i], d[i]);
				if (t1 > t2) begin
					x = t1;
					t1 = t2;
					t2 = x;
				end
				if (t1 > tmin) tmin = t1;
				if (t2 < tmax) tmax = t2;
				if (tmin > tmax) hit = 1'b0;
			end
		end
		t = mode_entry ? tmin : tmax;
		for (int i = 0; i < 3; i++) pt[i] = hit ? point_at(o[i], d[i], t) : 0;
		e.hit = hit;
		e.point_x = coord_t'(pt[0]);
		e.point_y = coord_t'(pt[1]);
		e.point_z = coord_t'(pt[2]);
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
		errors++;
	endtask

	// driver
	always @(negedge clk) begin
		if (!ray_valid || in_taken) begin
			if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				ray <= pending_rays.pop_front();
				ray_valid <= 1'b1;
			end else ray_valid <= 1'b0;
		end
		res_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** ray_box_slab_intersect_unit: FAILED **");
			$finish;
		end
		in_taken = arst_n && ray_valid && ray_ready;
		if (in_taken) begin
			expected_hits.push_back(slab_intersect(ray));
			rays_sent++;
		end
		if (arst_n && res_valid && res_ready) begin
			if (expected_hits.size() == 0) begin
				$display("unexpected result transfer");
				errors++;
			end else begin
				res_t e;
				e = expected_hits.pop_front();
				if (res.hit !== e.hit) report_mismatch("hit", 32'(res.hit), 32'(e.hit));
				if (res.point_x !== e.point_x) report_mismatch("point_x", res.point_x, e.point_x);
				if (res.point_y !== e.point_y) report_mismatch("point_y", res.point_y, e.point_y);
				if (res.point_z !== e.point_z) report_mismatch("point_z", res.point_z, e.point_z);
				if (e.hit) hits_seen++;
			end
			results_seen++;
		end
	end

	function automatic coord_t rand_coord(int k);
		case ($urandom_range(5))
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(7) == 0 ? TMAX_C : CMIN_C);
			2: return coord_t'(int'($urandom_range(16)) - 8);
			3: return coord_t'((int'($urandom_range(400)) - 200) <<< (FRAC_W - k));
			default: return coord_t'((int'($urandom_range(40)) - 20) <<< FRAC_W);
		endcase
	endfunction

	function automatic ray_t rand_ray();
		ray_t r;
		coord_t a, b;
		r.origin_x = rand_coord(0);
		r.origin_y = rand_coord(0);
		r.origin_z = rand_coord(0);
		r.dir_x = rand_coord(2);
		r.dir_y = rand_coord(2);
		r.dir_z = rand_coord(2);
		for (int i = 0; i < 3; i++) begin
			a = rand_coord(0);
			b = rand_coord(0);
			// keep boxes mostly well ordered so rays reach the hit path
			if ($urandom_range(9) != 0 && a > b) begin
				coord_t x;
				x = a; a = b; b = x;
			end
			case (i)
				0: begin r.box_min_x = a; r.box_max_x = b; end
				1: begin r.box_min_y = a; r.box_max_y = b; end
				default: begin r.box_min_z = a; r.box_max_z = b; end
			endcase
		end
		return r;
	endfunction

	function automatic ray_t box_ray(coord_t o, coord_t d, coord_t lo, coord_t hi);
		ray_t r;
		r = '{o, o, o, d, d, d, lo, lo, lo, hi, hi, hi};
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENTRY_MODE) mode_entry = v[0];
		else par_thresh = v;
	endtask

	task automatic drain();
		while (pending_rays.size() > 0 || ray_valid || expected_hits.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic run_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) pending_rays.push_back(rand_ray());
		drain();
	endtask

	initial begin
		coord_t one;
		one = coord_t'(1 <<< FRAC_W);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: hits, misses, parallel axes, zero direction, extremes, inverted box
		pending_rays.push_back(box_ray('0, one, one, 3 * one));
		pending_rays.push_back(box_ray(5 * one, -one, one, 3 * one));
		pending_rays.push_back(box_ray(5 * one, one, one, 3 * one));
		pending_rays.push_back(box_ray(2 * one, '0, one, 3 * one));
		pending_rays.push_back(box_ray(5 * one, '0, one, 3 * one));
		pending_rays.push_back(box_ray(2 * one, '0, 3 * one, one));
		pending_rays.push_back(box_ray('0, one, 3 * one, one));
		pending_rays.push_back(box_ray(CMIN_C, TMAX_C, CMIN_C, TMAX_C));
		pending_rays.push_back(box_ray(TMAX_C, CMIN_C, CMIN_C, TMAX_C));
		pending_rays.push_back(box_ray('0, coord_t'(1), CMIN_C, TMAX_C));
		pending_rays.push_back(box_ray('0, coord_t'(-1), CMIN_C, TMAX_C));
		pending_rays.push_back(box_ray('0, coord_t'(2), one, TMAX_C));
		pending_rays.push_back(box_ray('0, '1, CMIN_C, '0));
		pending_rays.push_back(box_ray(CMIN_C, coord_t'(2), TMAX_C, TMAX_C));
		pending_rays.push_back(box_ray('0, '0, '0, '0));
		run_phase(0, 0, 0);
		write_reg(REG_ENTRY_MODE, 16'd1);
		for (int i = 0; i < 15; i++) pending_rays.push_back(pending_rays.size() == 0 ?
			box_ray('0, one, one, 3 * one) : box_ray('0, one, one, 3 * one));
		run_phase(0, 0, 0);

		write_reg(REG_PAR_THRESH, 16'd0);
		run_phase(120, 0, 0);
		write_reg(REG_ENTRY_MODE, 16'd0);
		write_reg(REG_PAR_THRESH, 16'hFFFF);
		run_phase(120, 63, 0);
		write_reg(REG_PAR_THRESH, 16'h0100);
		run_phase(120, 0, 63);
		write_reg(REG_ENTRY_MODE, 16'd1);
		run_phase(120, 16, 16);

		// long receiver hold-off so the pipeline backs up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b1;
		for (int i = 0; i < 120; i++) pending_rays.push_back(rand_ray());
		for (int i = 0; i < 3 * LATENCY; i++) @(negedge clk);
		recv_hold = 1'b0;
		drain();
		write_reg(REG_PAR_THRESH, 16'd1);
		run_phase(100, 0, 0);

		$display("sent %0d rays, checked %0d results (%0d hits)", rays_sent, results_seen,
			hits_seen);
		$display("covered both point modes, thresholds 0/1/256/65535 and idle/stall mixes");
		if (errors == 0 && expected_hits.size() == 0)
			$display("** ray_box_slab_intersect_unit: PASSED **");
		else
			$display("** ray_box_slab_intersect_unit: FAILED **");
		$finish;
	end
endmodule
